/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the escape-token decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// Types and constants shared by the decompressor modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lzd_pkg;
  localparam logic [7:0] EscShort = 8'hFE;
  localparam logic [7:0] EscLong  = 8'hFF;
  localparam logic [8:0] LenBias  = 9'd3;

  // Number of byte lanes in one output transfer; the port list has this many.
  localparam int unsigned OutputLanes = 8;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrOffset    = 2'd1,
    ErrTruncated = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhCode   = 3'd1,
    PhOffS   = 3'd2,
    PhOffHi  = 3'd3,
    PhOffLo  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StCopy = 2'd1,
    StEmit = 2'd2
  } state_e;
endpackage
`default_nettype wire

/* rtl/lz77_escape_token_decompressor.sv */
// ----------------------------------------------------------------------------
// lz77_escape_token_decompressor
// Escape-token LZ77 decoder: one compressed byte in, packed byte groups out.
// ----------------------------------------------------------------------------
// Timing: a literal, escape, length code or offset byte is accepted and its
// result sits in an output register, so header bytes flow one per cycle
// while the output is taken. A match of N bytes is copied by a sequencer
// that reads one history byte per cycle, while a group has room, through the
// single read port of the history memory (the registered read overlaps the
// next read). Each group of up to eight bytes is copied and then handed to
// the output register, so after the offset byte the input is blocked until
// the last group of the match is handed off, which waits while the output is
// not taken. The history memory needs no clearing after reset.
`default_nettype none
`include "assert_macros.svh"
module lz77_escape_token_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  compressed_byte_i,
  input  wire logic        stream_last_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [7:0]       lane0_o,
  output logic [7:0]       lane1_o,
  output logic [7:0]       lane2_o,
  output logic [7:0]       lane3_o,
  output logic [7:0]       lane4_o,
  output logic [7:0]       lane5_o,
  output logic [7:0]       lane6_o,
  output logic [7:0]       lane7_o,
  output logic [3:0]       byte_count_o,
  output logic             run_last_o,
  output logic             stream_end_o,
  output logic [1:0]       error_code_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);
  import lzd_pkg::*;

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned PW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LW = $clog2(OutputLanes + 1);
  localparam int unsigned NW = (OutputLanes > 1) ? $clog2(OutputLanes) : 1;
  localparam logic [PW-1:0] Depth = PW'(HISTORY_DEPTH);

  // History window.
  logic [7:0] hist_mem [HISTORY_DEPTH];
  logic [7:0] rd_data_q;
  logic       hist_we;
  logic [AW-1:0] hist_wa, hist_ra;
  logic [7:0] hist_wd;

  // A read of the entry written in the same cycle returns the new byte.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    rd_data_q <= (hist_we && hist_wa == hist_ra) ? hist_wd : hist_mem[hist_ra];
  end

  // Control and payload registers.
  state_e         state_q, state_d;
  phase_e         phase_q, phase_d;
  logic           long_q, long_d;
  logic [7:0]     code_q, code_d;
  logic [7:0]     ofs_hi_q, ofs_hi_d;
  logic           failed_q, failed_d;
  logic [AW-1:0]  wp_q, wp_d;
  logic [PW-1:0]  prod_q, prod_d;
  logic [AW-1:0]  src_q, src_d;
  logic [8:0]     left_q, left_d;
  logic           rd_pend_q, rd_pend_d;
  logic           last_q, last_d;
  logic [7:0]     lane_q [OutputLanes];
  logic [7:0]     lane_d [OutputLanes];
  logic [LW-1:0]  cnt_q, cnt_d;
  logic           ov_q, ov_d;
  logic           rl_q, rl_d, se_q, se_d;
  err_e           err_q, err_d;

  logic           in_fire, out_fire;
  logic [16:0]    offset;
  logic           bad_ofs;
  logic [PW-1:0]  ofs_w;

  // Advance a history address, wrapping at the window size.
  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    return (a == AW'(HISTORY_DEPTH - 1)) ? '0 : AW'(a + AW'(1));
  endfunction

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = ov_q && out_ready_i;
  assign in_ready_o = (state_q == StIdle) && (!ov_q || out_ready_i);

  // Offset check shared by the short and long forms.
  always_comb begin
    if (phase_q == PhOffLo) begin
      offset = {1'b0, ofs_hi_q, compressed_byte_i};
    end else begin
      offset = {9'd0, compressed_byte_i};
    end
    ofs_w   = PW'(offset);
    bad_ofs = (offset == 17'd0) || (17'(offset) > 17'(prod_q)) ||
              (offset > 17'(HISTORY_DEPTH));
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire && !failed_q && !bad_ofs &&
                  (phase_q == PhOffS || phase_q == PhOffLo)) state_d = StCopy;
      StCopy: if (rd_pend_q && (left_q == 9'd0 ||
                  cnt_q == LW'(OutputLanes - 1))) state_d = StEmit;
      StEmit: if (!ov_q || out_ready_i) state_d = (left_q == 9'd0) ? StIdle : StCopy;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_d = phase_q; long_d = long_q; code_d = code_q; ofs_hi_d = ofs_hi_q;
    failed_d = failed_q; wp_d = wp_q; prod_d = prod_q; src_d = src_q;
    left_d = left_q; rd_pend_d = 1'b0; last_d = last_q;
    lane_d = lane_q; cnt_d = cnt_q; ov_d = ov_q; rl_d = rl_q; se_d = se_q;
    err_d = err_q;
    hist_we = 1'b0; hist_wa = wp_q; hist_wd = compressed_byte_i; hist_ra = src_q;
    if (out_fire) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          logic lit;
          logic emit;
          lit = 1'b0;
          emit = 1'b0;
          err_d = ErrNone;
          cnt_d = '0;
          last_d = stream_last_i;
          for (int i = 0; i < OutputLanes; i++) lane_d[i] = 8'd0;
          if (!failed_q) begin
            unique case (phase_q)
              PhStart: begin
                if (compressed_byte_i == EscShort) begin
                  phase_d = PhCode; long_d = 1'b0;
                end else if (compressed_byte_i == EscLong) begin
                  phase_d = PhCode; long_d = 1'b1;
                end else lit = 1'b1;
              end
              PhCode: begin
                if (compressed_byte_i == (long_q ? EscLong : EscShort)) begin
                  lit = 1'b1; phase_d = PhStart;
                end else begin
                  code_d = compressed_byte_i;
                  phase_d = long_q ? PhOffHi : PhOffS;
                end
              end
              PhOffHi: begin
                ofs_hi_d = compressed_byte_i; phase_d = PhOffLo;
              end
              PhOffS, PhOffLo: begin
                phase_d = PhStart;
                if (bad_ofs) err_d = ErrOffset;
                else begin
                  // Source address is the write pointer minus the offset,
                  // modulo the window size.
                  src_d = (ofs_w > PW'(wp_q)) ? AW'(PW'(wp_q) + Depth - ofs_w) :
                                                AW'(PW'(wp_q) - ofs_w);
                  left_d = {1'b0, code_q} + LenBias;
                end
              end
              default: phase_d = PhStart;
            endcase
            if (err_d == ErrNone && stream_last_i && phase_d != PhStart &&
                !(phase_q == PhOffS || phase_q == PhOffLo)) err_d = ErrTruncated;
          end
          if (lit) begin
            hist_we = 1'b1;
            lane_d[0] = compressed_byte_i;
            cnt_d = LW'(1);
            wp_d = next_addr(wp_q);
            if (prod_q < Depth) prod_d = prod_q + PW'(1);
          end
          emit = lit || (err_d != ErrNone) || (stream_last_i &&
                 !(state_d == StCopy));
          if (state_d != StCopy) begin
            ov_d = emit;
            rl_d = 1'b1;
            se_d = stream_last_i;
            if (stream_last_i) begin
              wp_d = '0; prod_d = '0; phase_d = PhStart; long_d = 1'b0;
              code_d = '0; ofs_hi_d = '0; failed_d = 1'b0;
            end else if (err_d != ErrNone) failed_d = 1'b1;
          end
        end
      end
      StCopy: begin
        // Issue a read each cycle while bytes remain and the group has room; write back the byte read last cycle.
        if (left_q != 9'd0 && !(rd_pend_q && cnt_q == LW'(OutputLanes - 1))) begin
          hist_ra = src_q;
          src_d = next_addr(src_q);
          left_d = left_q - 9'd1;
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          hist_we = 1'b1;
          hist_wd = rd_data_q;
          lane_d[NW'(cnt_q)] = rd_data_q;
          cnt_d = cnt_q + LW'(1);
          wp_d = next_addr(wp_q);
          if (prod_q < Depth) prod_d = prod_q + PW'(1);
        end
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          rl_d = (left_q == 9'd0);
          se_d = (left_q == 9'd0) && last_q;
          err_d = ErrNone;
          if (left_q == 9'd0 && last_q) begin
            wp_d = '0; prod_d = '0; phase_d = PhStart; long_d = 1'b0;
            code_d = '0; ofs_hi_d = '0; failed_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Lane buffer is loaded with the finished group when it is handed off, or with the new lanes on an idle accept.
  logic [7:0]    lb_q [OutputLanes];
  logic [LW-1:0] lbc_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StEmit && state_d != StEmit) begin
      lb_q  <= lane_q;
      lbc_q <= cnt_q;
    end else if (state_q == StIdle && in_fire) begin
      lb_q  <= lane_d;
      lbc_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; phase_q <= PhStart; long_q <= 1'b0; code_q <= '0;
      ofs_hi_q <= '0; failed_q <= 1'b0; wp_q <= '0; prod_q <= '0;
      left_q <= '0; rd_pend_q <= 1'b0; ov_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; long_q <= long_d; code_q <= code_d;
      ofs_hi_q <= ofs_hi_d; failed_q <= failed_d; wp_q <= wp_d; prod_q <= prod_d;
      left_q <= left_d; rd_pend_q <= rd_pend_d; ov_q <= ov_d;
      cnt_q <= (state_q == StEmit && state_d != StEmit) ? '0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
  end
  always_ff @(posedge clk_i) begin
    last_q <= last_d; rl_q <= rl_d; se_q <= se_d; err_q <= err_d;
    for (int i = 0; i < OutputLanes; i++) begin
      lane_q[i] <= (state_q == StEmit && state_d != StEmit) ? 8'd0 : lane_d[i];
    end
  end

  assign out_valid_o  = ov_q;
  assign lane0_o = lb_q[0]; assign lane1_o = lb_q[1];
  assign lane2_o = lb_q[2]; assign lane3_o = lb_q[3];
  assign lane4_o = lb_q[4]; assign lane5_o = lb_q[5];
  assign lane6_o = lb_q[6]; assign lane7_o = lb_q[7];
  assign byte_count_o = 4'(lbc_q);
  assign run_last_o   = rl_q;
  assign stream_end_o = se_q;
  assign error_code_o = err_q;

  `ASSERT_NEXT(a_no_accept_in_copy, clk_i, rst_ni, state_q == StCopy, !in_fire)
  `ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= LW'(OutputLanes))
  `ASSERT_IMPLIES(a_err_empty, clk_i, rst_ni, ov_q && err_q != ErrNone, lbc_q == '0)
endmodule
`default_nettype wire

/* tb/lz77_escape_token_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_escape_token_checker
// Watches both channels of the decompressor, decodes every accepted byte
// with its own escape-token parser and history window, and compares each
// output transfer with the oldest predicted byte group.
// ----------------------------------------------------------------------------
module lz77_escape_token_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] compressed_byte_i,
  input  wire logic       stream_last_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] lane_i [8],
  input  wire logic [3:0] byte_count_i,
  input  wire logic       run_last_i,
  input  wire logic       stream_end_i,
  input  wire logic [1:0] error_code_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  output int              fail_count_o,
  output int              pending_o
);
  import lzd_pkg::*;

  localparam int unsigned Depth = 65536;

  typedef struct packed {
    logic [7:0][7:0] lanes;
    logic [3:0]      count;
    logic            run_last;
    logic            stream_end;
    err_e            err;
  } group_t;

  group_t      groups_q[$];
  logic [7:0]  window[Depth];
  logic [15:0] wr_ptr;
  int unsigned produced;
  phase_e      phase;
  logic        long_tok;
  logic [7:0]  len_code;
  logic [7:0]  off_hi;
  logic        failed;

  assign pending_o = groups_q.size();

  function automatic void store_byte(input logic [7:0] v);
    window[wr_ptr] = v;
    wr_ptr = wr_ptr + 16'd1;
    if (produced < Depth) produced++;
  endfunction

  // Copy a match into the byte list; returns 1 on a bad offset.
  function automatic logic copy_match(input int unsigned off, ref logic [7:0] bytes[$]);
    logic [7:0] v;
    if (off == 0 || off > produced) return 1'b1;
    for (int j = 0; j < int'(len_code) + int'(LenBias); j++) begin
      v = window[16'(wr_ptr - off)];
      bytes = {bytes, v};
      store_byte(v);
    end
    return 1'b0;
  endfunction

  function automatic void push_group(input logic [7:0] bytes[$], input int base,
                                     input int cnt, input logic rl, input logic se,
                                     input err_e e);
    group_t g;
    g = '0;
    for (int i = 0; i < cnt; i++) g.lanes[i] = bytes[base + i];
    g.count = 4'(cnt);
    g.run_last = rl;
    g.stream_end = se;
    g.err = e;
    groups_q = {groups_q, g};
  endfunction

  // Decode one accepted compressed byte.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [7:0] bytes[$];
    err_e       e;
    int         cnt;
    logic       fin;
    e = ErrNone;
    if (!failed) begin
      case (phase)
        PhStart: begin
          if (b == EscShort || b == EscLong) begin
            phase = PhCode;
            long_tok = (b == EscLong);
          end else begin
            bytes = {bytes, b};
            store_byte(b);
          end
        end
        PhCode: begin
          if (b == (long_tok ? EscLong : EscShort)) begin
            bytes = {bytes, b};
            store_byte(b);
            phase = PhStart;
          end else begin
            len_code = b;
            phase = long_tok ? PhOffHi : PhOffS;
          end
        end
        PhOffS: begin
          phase = PhStart;
          if (copy_match(b, bytes)) e = ErrOffset;
        end
        PhOffHi: begin
          off_hi = b;
          phase = PhOffLo;
        end
        default: begin
          phase = PhStart;
          if (copy_match({off_hi, b}, bytes)) e = ErrOffset;
        end
      endcase
      if (e == ErrNone && last && phase != PhStart) e = ErrTruncated;
    end
    if (e != ErrNone) begin
      push_group(bytes, 0, 0, 1'b1, last, e);
    end else if (bytes.size() > 0) begin
      for (int pos = 0; pos < bytes.size(); pos += 8) begin
        cnt = (bytes.size() - pos < 8) ? bytes.size() - pos : 8;
        fin = (pos + cnt >= bytes.size());
        push_group(bytes, pos, cnt, fin, fin & last, ErrNone);
      end
    end else if (last) begin
      push_group(bytes, 0, 0, 1'b1, 1'b1, ErrNone);
    end
    if (last) begin
      wr_ptr = '0;
      produced = 0;
      phase = PhStart;
      long_tok = 1'b0;
      len_code = '0;
      off_hi = '0;
      failed = 1'b0;
    end else if (e != ErrNone) begin
      failed = 1'b1;
    end
  endfunction

  // Compare one output transfer with the oldest predicted group.
  task automatic check_group();
    group_t g;
    if (groups_q.size() == 0) begin
      $error("unexpected output transfer");
      fail_count_o++;
      return;
    end
    g = groups_q.pop_front();
    for (int i = 0; i < 8; i++) begin
      if (lane_i[i] !== g.lanes[i]) begin
        $error("lane%0d: expected %0h, got %0h", i, g.lanes[i], lane_i[i]);
        fail_count_o++;
      end
    end
    if (byte_count_i !== g.count) begin
      $error("byte_count: expected %0d, got %0d", g.count, byte_count_i);
      fail_count_o++;
    end
    if (run_last_i !== g.run_last) begin
      $error("run_last: expected %0b, got %0b", g.run_last, run_last_i);
      fail_count_o++;
    end
    if (stream_end_i !== g.stream_end) begin
      $error("stream_end: expected %0b, got %0b", g.stream_end, stream_end_i);
      fail_count_o++;
    end
    if (error_code_i !== g.err) begin
      $error("error_code: expected %0d, got %0d", g.err, error_code_i);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    wr_ptr = '0;
    produced = 0;
    phase = PhStart;
    long_tok = 1'b0;
    len_code = '0;
    off_hi = '0;
    failed = 1'b0;
  end

  // Sample both channels at every rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_group();
      if (in_valid_i && in_ready_i) decode_byte(compressed_byte_i, stream_last_i);
    end
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives compressed streams into the decompressor: directed corner cases,
// then random streams built mostly from well-formed tokens, with random
// gaps on both channels. The checker reports mismatches; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb;
  import lzd_pkg::*;

  localparam int IdleLimit = 20000;

  logic       clk;
  logic       rst_n;
  logic [7:0] comp_byte;
  logic       comp_last;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] lanes [8];
  logic [3:0] byte_count;
  logic       run_last;
  logic       stream_end;
  logic [1:0] error_code;
  logic       out_valid;
  logic       out_ready;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  int         produced;
  int         sent_count;

  lz77_escape_token_decompressor dut (
    .clk_i(clk), .rst_ni(rst_n),
    .compressed_byte_i(comp_byte), .stream_last_i(comp_last),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .lane0_o(lanes[0]), .lane1_o(lanes[1]), .lane2_o(lanes[2]), .lane3_o(lanes[3]),
    .lane4_o(lanes[4]), .lane5_o(lanes[5]), .lane6_o(lanes[6]), .lane7_o(lanes[7]),
    .byte_count_o(byte_count), .run_last_o(run_last), .stream_end_o(stream_end),
    .error_code_o(error_code), .out_valid_o(out_valid), .out_ready_i(out_ready)
  );

  lz77_escape_token_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .compressed_byte_i(comp_byte), .stream_last_i(comp_last),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .lane_i(lanes), .byte_count_i(byte_count), .run_last_i(run_last),
    .stream_end_i(stream_end), .error_code_i(error_code),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one compressed byte after a random gap and wait for its transfer.
  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    comp_byte <= b;
    comp_last <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
    // Track the stream length so that most offsets stay in range.
    if (last) produced = 0;
  endtask

  task automatic send_literal(input logic [7:0] b, input logic last);
    if (b == EscShort || b == EscLong) begin
      send_byte(b, 1'b0);
      send_byte(b, last);
    end else begin
      send_byte(b, last);
    end
    produced = last ? 0 : produced + 1;
  endtask

  // Short or long match token; the code must not collide with the escape.
  task automatic send_match(input logic long_tok, input logic [7:0] code,
                            input logic [15:0] off, input logic last);
    send_byte(long_tok ? EscLong : EscShort, 1'b0);
    send_byte(code, 1'b0);
    if (long_tok) send_byte(off[15:8], 1'b0);
    send_byte(off[7:0], last);
    produced = last ? 0 : produced + int'(code) + 3;
  endtask

  // Pick an offset that is valid for the bytes produced so far.
  function automatic logic [15:0] pick_offset(input logic long_tok);
    int hi;
    hi = long_tok ? produced : (produced < 255 ? produced : 255);
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(1, hi));
  endfunction

  // Mostly short copies; long tokens get a slightly wider spread.
  function automatic logic [7:0] pick_code(input logic long_tok);
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 253));
    else c = 8'($urandom_range(0, long_tok ? 30 : 20));
    return c;
  endfunction

  // Random sink stalls.
  initial begin
    int wait_n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (wait_n - 1) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("lz77_escape_token_decompressor regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic lt;
    int   kind;
    comp_byte = '0;
    comp_last = 1'b0;
    in_valid = 1'b0;
    produced = 0;
    sent_count = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: literals at the extremes, escaped literals, both match
    // forms with overlap, long copy, bad offsets, truncation, empty end.
    send_byte(8'h00, 1'b1);
    send_literal(8'h00, 1'b0);
    send_literal(8'hFD, 1'b0);
    send_literal(EscShort, 1'b0);
    send_literal(EscLong, 1'b0);
    send_match(1'b0, 8'h00, 16'd1, 1'b0);
    send_match(1'b1, 8'd253, 16'd4, 1'b0);
    send_match(1'b0, 8'h05, 16'd255, 1'b1);
    send_literal(8'h55, 1'b0);
    send_match(1'b0, 8'h02, 16'd0, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_literal(8'hAA, 1'b0);
    send_match(1'b1, 8'h01, 16'hFFFF, 1'b1);
    send_byte(EscLong, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(EscShort, 1'b1);
    send_match(1'b0, 8'h00, 16'd1, 1'b1);

    // Random streams: mostly valid tokens, some noise and broken ones.
    while (sent_count < 100) begin
      kind = $urandom_range(0, 19);
      lt = 1'($urandom_range(0, 1));
      if (kind < 8 || produced == 0) begin
        send_literal(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else if (kind < 16) begin
        send_match(lt, pick_code(lt), pick_offset(lt), $urandom_range(0, 15) == 0);
      end else if (kind < 18) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        produced = 0;
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_match(lt, pick_code(lt), 16'($urandom_range(0, 65535)), 1'b1);
      end
    end
    send_byte(8'h00, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("lz77_escape_token_decompressor regression: pass");
    else $display("lz77_escape_token_decompressor regression: fail");
    $finish;
  end
endmodule
